// ===== rtl/qrde_pkg.sv =====
// Shared sizes and types for the replica delta-energy engine.
// No dependencies; every other rtl file refers to it by scoped names.
`default_nettype none

package qrde_pkg;

   // Storage limits
   localparam int MAX_BITS   = 256;
   localparam int MAX_LAYERS = 16;

   // Index and count widths that follow from the limits
   localparam int BIT_IDX_W   = $clog2(MAX_BITS);
   localparam int BIT_CNT_W   = $clog2(MAX_BITS + 1);
   localparam int LAYER_IDX_W = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
   localparam int LAYER_CNT_W = $clog2(MAX_LAYERS + 1);
   localparam int CPL_ADDR_W  = 2 * BIT_IDX_W;

   // Arithmetic widths
   localparam int CPL_W  = 16;
   localparam int COEF_W = 16;
   localparam int SUM_W  = CPL_W + BIT_CNT_W;
   localparam int PROD_W = COEF_W + SUM_W;
   localparam int DE_W   = 48;

   // Fixed point scale of the classical result (8 fraction bits)
   localparam int FRAC_ONE = 256;

   // Control of the replica row store
   typedef struct packed {
      logic                   rd_en;
      logic                   wr_en;
      logic [LAYER_IDX_W-1:0] rd_addr;
      logic [LAYER_IDX_W-1:0] wr_addr;
   } rep_req_type;

endpackage

`default_nettype wire

// ===== rtl/qrde_replica_store.sv =====
// Ring of replica bit rows, one row per layer, with a valid bit per row.
// Depends on qrde_pkg for sizes and the request struct.
`default_nettype none

module qrde_replica_store (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire qrde_pkg::rep_req_type        req,
   input  wire logic [qrde_pkg::MAX_BITS-1:0] wr_data,
   output logic      [qrde_pkg::MAX_BITS-1:0] rd_data
);

   logic [qrde_pkg::MAX_BITS-1:0]   rows_ff [qrde_pkg::MAX_LAYERS];
   logic [qrde_pkg::MAX_LAYERS-1:0] valid_ff;
   logic [qrde_pkg::MAX_BITS-1:0]   q_ff;
   logic                            q_valid_ff;

   // Row valid bits: a row never written reads as zeros
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         q_valid_ff <= 1'b0;
      end else begin
         if (req.wr_en) begin
            valid_ff[req.wr_addr] <= 1'b1;
         end
         if (req.rd_en) begin
            q_valid_ff <= valid_ff[req.rd_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         rows_ff[req.wr_addr] <= wr_data;
      end
      if (req.rd_en) begin
         q_ff <= rows_ff[req.rd_addr];
      end
   end

   assign rd_data = q_ff & {qrde_pkg::MAX_BITS{q_valid_ff}};

endmodule

`default_nettype wire

// ===== rtl/qubo_replica_delta_energy.sv =====
// Top level of the replica delta-energy engine: sequencer, coupling memory,
// shared accumulate/multiply datapath and result register.
// Depends on qrde_pkg and qrde_replica_store.
//
//   channel | direction | handshake             | contents
//   --------+-----------+-----------------------+-------------------------------------
//   req_    | in        | tvalid/tready         | tuser: cmd; tdata: row, col, layer,
//           |           |                       |   coupling, bit_value
//   rsp_    | out       | tvalid/tready         | tdata: delta_energy; tuser: is_classical
//   csr_    | in        | we (no wait)          | addr: register index; wdata: value
//
// A coupling write is stored on the accepted beat; a bit write reads, modifies and
// writes back one replica row. In a query the row sum reads one coupling entry a cycle
// from the coupling memory, and the layer wrap is one subtract a cycle. Reset clears
// the replica rows at once through row valid bits; the coupling memory is not cleared.
// req_tready is high only between items; a finished result waits in the output
// register and does not hold off the next item, but a later query holds in its last
// step until that beat is taken.
`default_nettype none

module qubo_replica_delta_energy (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,   // row[7:0], col[15:8], layer[19:16],
                                         // coupling[35:20], bit_value[36], zeros
   input  wire logic [1:0]  req_tuser,   // cmd[1:0]
   // response channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,   // delta_energy[47:0]
   output logic [0:0]       rsp_tuser,   // is_classical[0]
   // configuration
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_addr,
   input  wire logic [15:0] csr_wdata
);

   typedef enum logic [1:0] {
      CMD_WR_CPL  = 2'd0,
      CMD_WR_BIT  = 2'd1,
      CMD_Q_DELTA = 2'd2,
      CMD_C_DELTA = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      CSR_ACTIVE_BITS   = 2'd0,
      CSR_ACTIVE_LAYERS = 2'd1,
      CSR_A_COEF        = 2'd2,
      CSR_B_PER_LAYER   = 2'd3
   } csr_idx_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_BW_RD,
      ST_BW_WR,
      ST_MOD,
      ST_RD_OWN,
      ST_RD_NX,
      ST_RD_PV,
      ST_GRAB,
      ST_ACC,
      ST_MUL,
      ST_FIN
   } state_type;

   localparam int BIW = qrde_pkg::BIT_IDX_W;
   localparam int BCW = qrde_pkg::BIT_CNT_W;
   localparam int LIW = qrde_pkg::LAYER_IDX_W;
   localparam int LCW = qrde_pkg::LAYER_CNT_W;

   // ---------------------------------------------------------------- registers
   state_type                          state_ff, state_in;
   logic                               rsp_valid_ff, rsp_valid_in;

   logic [8:0]                         act_bits_ff;
   logic [4:0]                         act_layers_ff;
   logic signed [qrde_pkg::COEF_W-1:0] a_coef_ff;
   logic signed [qrde_pkg::COEF_W-1:0] b_ff;

   cmd_type                            cmd_ff, cmd_in;
   logic [7:0]                         row_ff, row_in;
   logic [3:0]                         lay_ff, lay_in;
   logic                               val_ff, val_in;
   logic                               row_ok_ff, row_ok_in;
   logic [BCW-1:0]                     n_ff, n_in;
   logic [LCW-1:0]                     lcnt_ff, lcnt_in;
   logic [LCW-1:0]                     ql_ff, ql_in;
   logic [LCW-1:0]                     nx_ff, nx_in;
   logic [LCW-1:0]                     pv_ff, pv_in;
   logic [qrde_pkg::MAX_BITS-1:0]      rowbits_ff, rowbits_in;
   logic                               own_ff, own_in;
   logic                               nbx_ff, nbx_in;
   logic                               nbp_ff, nbp_in;
   logic [BCW-1:0]                     cnt_ff, cnt_in;
   logic                               pend_ff, pend_in;
   logic                               pbit_ff, pbit_in;
   logic signed [qrde_pkg::SUM_W-1:0]  sum_ff, sum_in;
   logic signed [qrde_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic signed [qrde_pkg::DE_W-1:0]   rsp_de_ff, rsp_de_in;
   logic                               rsp_cls_ff, rsp_cls_in;

   // coupling memory
   logic signed [qrde_pkg::CPL_W-1:0]  cpl_mem_ff [2**qrde_pkg::CPL_ADDR_W];
   logic signed [qrde_pkg::CPL_W-1:0]  cpl_q_ff;

   // ---------------------------------------------------------------- signals
   logic                               req_acc;
   cmd_type                            in_cmd;
   logic [7:0]                         in_row;
   logic [7:0]                         in_col;
   logic [3:0]                         in_layer;
   logic signed [qrde_pkg::CPL_W-1:0]  in_coupling;
   logic                               in_bit;
   logic                               in_row_ok;
   logic                               in_col_ok;
   logic                               in_layer_ok;

   logic [BCW-1:0]                     eff_bits;
   logic [LCW-1:0]                     eff_layers;

   logic                               cpl_we;
   logic [qrde_pkg::CPL_ADDR_W-1:0]    cpl_waddr;
   logic                               cpl_rd_en;
   logic [qrde_pkg::CPL_ADDR_W-1:0]    cpl_raddr;

   qrde_pkg::rep_req_type              rep_req;
   logic [qrde_pkg::MAX_BITS-1:0]      rep_wr_data;
   logic [qrde_pkg::MAX_BITS-1:0]      rep_rd_data;
   logic [BIW-1:0]                     r_idx;
   logic                               rep_bit;

   logic signed [qrde_pkg::COEF_W-1:0] mul_a;
   logic signed [qrde_pkg::COEF_W+1:0] bterm;
   logic signed [qrde_pkg::DE_W-1:0]   total;
   logic signed [qrde_pkg::DE_W-1:0]   de_val;
   logic                               out_free;

   // ---------------------------------------------------------------- unpack
   assign in_cmd      = cmd_type'(req_tuser);
   assign in_row      = req_tdata[7:0];
   assign in_col      = req_tdata[15:8];
   assign in_layer    = req_tdata[19:16];
   assign in_coupling = req_tdata[35:20];
   assign in_bit      = req_tdata[36];

   assign in_row_ok   = 32'(in_row) < qrde_pkg::MAX_BITS;
   assign in_col_ok   = 32'(in_col) < qrde_pkg::MAX_BITS;
   assign in_layer_ok = 32'(in_layer) < qrde_pkg::MAX_LAYERS;

   assign req_tready  = (state_ff == ST_IDLE);
   assign req_acc     = req_tvalid && req_tready;

   // Clamp the register settings to what the storage holds
   always_comb begin
      if (32'(act_bits_ff) > qrde_pkg::MAX_BITS) begin
         eff_bits = BCW'(qrde_pkg::MAX_BITS);
      end else begin
         eff_bits = BCW'(act_bits_ff);
      end
      if (act_layers_ff == '0) begin
         eff_layers = LCW'(1);
      end else if (32'(act_layers_ff) > qrde_pkg::MAX_LAYERS) begin
         eff_layers = LCW'(qrde_pkg::MAX_LAYERS);
      end else begin
         eff_layers = LCW'(act_layers_ff);
      end
   end

   // Coupling writes go straight in on the accepted beat
   assign cpl_we    = req_acc && (in_cmd == CMD_WR_CPL) && in_row_ok && in_col_ok;
   assign cpl_waddr = {BIW'(in_row), BIW'(in_col)};

   // Bit of the queried index in the row that came back from the replica store
   assign r_idx   = BIW'(row_ff);
   assign rep_bit = rep_rd_data[r_idx] && row_ok_ff;

   assign out_free = !rsp_valid_ff || rsp_tready;

   // Result assembly: both quantum terms share the sign of (2v-1), and the
   // classical sign (v-old) equals it whenever v differs from old. The widest
   // possible sum stays far inside 48 bits, so it cannot overflow.
   always_comb begin
      if (nbx_ff && nbp_ff) begin
         bterm = (qrde_pkg::COEF_W + 2)'(b_ff) <<< 1;
      end else if (!nbx_ff && !nbp_ff) begin
         bterm = -((qrde_pkg::COEF_W + 2)'(b_ff) <<< 1);
      end else begin
         bterm = '0;
      end
      total = qrde_pkg::DE_W'(prod_ff);
      if (cmd_ff == CMD_Q_DELTA) begin
         total = total + qrde_pkg::DE_W'(bterm);
      end
      if ((cmd_ff == CMD_C_DELTA) && (val_ff == own_ff)) begin
         de_val = '0;
      end else if (val_ff) begin
         de_val = total;
      end else begin
         de_val = -total;
      end
   end

   assign mul_a = (cmd_ff == CMD_C_DELTA) ? qrde_pkg::COEF_W'(qrde_pkg::FRAC_ONE)
                                          : a_coef_ff;

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd_in       = cmd_ff;
      row_in       = row_ff;
      lay_in       = lay_ff;
      val_in       = val_ff;
      row_ok_in    = row_ok_ff;
      n_in         = n_ff;
      lcnt_in      = lcnt_ff;
      ql_in        = ql_ff;
      nx_in        = nx_ff;
      pv_in        = pv_ff;
      rowbits_in   = rowbits_ff;
      own_in       = own_ff;
      nbx_in       = nbx_ff;
      nbp_in       = nbp_ff;
      cnt_in       = cnt_ff;
      pend_in      = pend_ff;
      pbit_in      = pbit_ff;
      sum_in       = sum_ff;
      prod_in      = prod_ff;
      rsp_de_in    = rsp_de_ff;
      rsp_cls_in   = rsp_cls_ff;

      rep_req      = '0;
      rep_wr_data  = rep_rd_data;
      cpl_rd_en    = 1'b0;
      cpl_raddr    = {r_idx, BIW'(cnt_ff)};

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               cmd_in    = in_cmd;
               row_in    = in_row;
               lay_in    = in_layer;
               val_in    = in_bit;
               row_ok_in = in_row_ok;
               n_in      = in_row_ok ? eff_bits : '0;
               lcnt_in   = eff_layers;
               ql_in     = LCW'(in_layer);
               case (in_cmd)
                  CMD_WR_CPL: state_in = ST_IDLE;
                  CMD_WR_BIT: state_in = (in_row_ok && in_layer_ok) ? ST_BW_RD : ST_IDLE;
                  default:    state_in = ST_MOD;
               endcase
            end
         end
         ST_BW_RD: begin
            rep_req.rd_en   = 1'b1;
            rep_req.rd_addr = LIW'(lay_ff);
            state_in        = ST_BW_WR;
         end
         ST_BW_WR: begin
            // modify the one bit of the row just read, write the row back
            rep_req.wr_en   = 1'b1;
            rep_req.wr_addr = LIW'(lay_ff);
            rep_wr_data     = (rep_rd_data & ~({{(qrde_pkg::MAX_BITS-1){1'b0}}, 1'b1} << r_idx))
                            | (qrde_pkg::MAX_BITS'(val_ff) << r_idx);
            state_in        = ST_IDLE;
         end
         ST_MOD: begin
            // wrap the layer into the ring, one subtract a cycle
            if (ql_ff >= lcnt_ff) begin
               ql_in = ql_ff - lcnt_ff;
            end else begin
               nx_in    = (LCW'(ql_ff + 1'b1) == lcnt_ff) ? '0 : LCW'(ql_ff + 1'b1);
               pv_in    = (ql_ff == '0) ? LCW'(lcnt_ff - 1'b1) : LCW'(ql_ff - 1'b1);
               state_in = ST_RD_OWN;
            end
         end
         ST_RD_OWN: begin
            rep_req.rd_en   = 1'b1;
            rep_req.rd_addr = LIW'(ql_ff);
            state_in        = ST_RD_NX;
         end
         ST_RD_NX: begin
            rep_req.rd_en   = 1'b1;
            rep_req.rd_addr = LIW'(nx_ff);
            rowbits_in      = rep_rd_data;
            own_in          = rep_bit;
            state_in        = ST_RD_PV;
         end
         ST_RD_PV: begin
            rep_req.rd_en   = 1'b1;
            rep_req.rd_addr = LIW'(pv_ff);
            nbx_in          = rep_bit;
            state_in        = ST_GRAB;
         end
         ST_GRAB: begin
            nbp_in   = rep_bit;
            cnt_in   = '0;
            pend_in  = 1'b0;
            sum_in   = '0;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            // issue one coupling read a cycle, add it in the cycle after
            if (cnt_ff < n_ff) begin
               cpl_rd_en  = 1'b1;
               pend_in    = 1'b1;
               pbit_in    = rowbits_ff[0];
               rowbits_in = rowbits_ff >> 1;
               cnt_in     = BCW'(cnt_ff + 1'b1);
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff && pbit_ff) begin
               sum_in = sum_ff + qrde_pkg::SUM_W'(cpl_q_ff);
            end
            if ((cnt_ff == n_ff) && !pend_ff) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = qrde_pkg::PROD_W'(mul_a) * qrde_pkg::PROD_W'(sum_ff);
            state_in = ST_FIN;
         end
         ST_FIN: begin
            // hold until the output register is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_de_in    = de_val;
               rsp_cls_in   = (cmd_ff == CMD_C_DELTA);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State, output valid and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         act_bits_ff   <= 9'd256;
         act_layers_ff <= 5'd16;
         a_coef_ff     <= 16'sd256;
         b_ff          <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_idx_type'(csr_addr))
               CSR_ACTIVE_BITS:   act_bits_ff   <= csr_wdata[8:0];
               CSR_ACTIVE_LAYERS: act_layers_ff <= csr_wdata[4:0];
               CSR_A_COEF:        a_coef_ff     <= csr_wdata;
               CSR_B_PER_LAYER:   b_ff          <= csr_wdata;
               default:           ;
            endcase
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      row_ff     <= row_in;
      lay_ff     <= lay_in;
      val_ff     <= val_in;
      row_ok_ff  <= row_ok_in;
      n_ff       <= n_in;
      lcnt_ff    <= lcnt_in;
      ql_ff      <= ql_in;
      nx_ff      <= nx_in;
      pv_ff      <= pv_in;
      rowbits_ff <= rowbits_in;
      own_ff     <= own_in;
      nbx_ff     <= nbx_in;
      nbp_ff     <= nbp_in;
      cnt_ff     <= cnt_in;
      pend_ff    <= pend_in;
      pbit_ff    <= pbit_in;
      sum_ff     <= sum_in;
      prod_ff    <= prod_in;
      rsp_de_ff  <= rsp_de_in;
      rsp_cls_ff <= rsp_cls_in;
   end

   // Coupling memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cpl_we) begin
         cpl_mem_ff[cpl_waddr] <= in_coupling;
      end
      if (cpl_rd_en) begin
         cpl_q_ff <= cpl_mem_ff[cpl_raddr];
      end
   end

   qrde_replica_store u_replica (
      .clock   (clock),
      .reset   (reset),
      .req     (rep_req),
      .wr_data (rep_wr_data),
      .rd_data (rep_rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_de_ff;
   assign rsp_tuser  = rsp_cls_ff;

   // ---------------------------------------------------------------- checks
   // A result beat appears only out of the final step of a query
   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_FIN))
      else $error("result raised outside the final step");

   // Coupling reads happen only while the row sum runs
   a_cpl_rd_acc: assert property (@(posedge clock) disable iff (reset)
      cpl_rd_en |-> (state_ff == ST_ACC))
      else $error("coupling read outside the row sum");

   // The multiply starts only with every entry issued and added
   a_sum_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL) |-> ((cnt_ff == n_ff) && !pend_ff))
      else $error("multiply started on an unfinished row sum");

   // A replica write is the second step of a bit write, after its row read
   a_rmw_order: assert property (@(posedge clock) disable iff (reset)
      rep_req.wr_en |-> ($past(state_ff) == ST_BW_RD))
      else $error("replica row written without a preceding read");

endmodule

`default_nettype wire
